/* src/rit_pkg.sv */
// Shared constants, codes and character helpers for the radix integer text parser.
`timescale 1ns / 1ps

package rit_pkg;

    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 64;
    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int RADIX_W     = 6;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_RADIX_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_SELECT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_MODE  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FORMAT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TRAILING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BASE     = 3'd5;

    localparam logic [RADIX_W-1:0] RADIX_AUTO    = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC     = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX     = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_BIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCT     = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LOWER_B = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LOWER_O = 8'h6F;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
               (c == 8'h0D) || (c == 8'h0C) || (c == 8'h0B);
    endfunction

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? c + CASE_OFFSET : c;
    endfunction

    // Returns {valid, value}; value is 0..35 when valid.
    function automatic logic [RADIX_W:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] l;
        logic [CHAR_W-1:0] v;
        l = fold_case(c);
        if ((l >= CH_ZERO) && (l <= CH_NINE))
        begin
            v = l - CH_ZERO;
            return {1'b1, v[RADIX_W-1:0]};
        end
        else if ((l >= CH_LOWER_A) && (l <= CH_LOWER_Z))
        begin
            v = l - CH_LOWER_A + 8'd10;
            return {1'b1, v[RADIX_W-1:0]};
        end
        return '0;
    endfunction

endpackage

/* src/rit_ifs.sv */
// Stream interfaces for the character input and the result output.
`timescale 1ns / 1ps

interface rit_char_if
    import rit_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              char_present;
    logic              end_of_text;

    modport source (output valid, output char_code, output char_present,
                    output end_of_text, input ready);
    modport sink   (input valid, input char_code, input char_present,
                    input end_of_text, output ready);
endinterface

interface rit_result_if
    import rit_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value_bits;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output value_bits, output status, input ready);
    modport sink   (input valid, input value_bits, input status, output ready);
endinterface

/* src/radix_integer_text_parser.sv */
// Top level of the radix integer text parser.
`timescale 1ns / 1ps
// Usage:
// The chars channel carries one word per character of a text: char_code,
// char_present (zero for a bare end marker) and end_of_text on the last word.
// The results channel carries one word per text: value_bits, extended to
// 64 bits, and status. Words without end_of_text produce no result.
// The configuration port writes radix_mode, width_select and signed_mode by
// index; the user must write them only while no text is in flight, as the
// block does not enforce it. radix_mode is taken at the first non-blank
// character of a text, the other two when the result is formed. Throughput
// is one character word per cycle while chars.ready is high: the parse state
// update is one multiply-accumulate of the magnitude by a 6-bit radix plus
// classification. An end word passes the input register, state snapshot and
// result register. When the receiver stalls, up to two finished texts wait in
// the snapshot and result registers while characters keep flowing; chars.ready
// drops only when a third end word reaches the input register with both of
// them full. Reset restores the register defaults (radix 10, 32 bits, signed)
// and clears the parse state; no result is pending after reset.
module radix_integer_text_parser
    import rit_pkg::*;
#(
    parameter int MAX_VALUE_WIDTH = 64
)(
    input  logic                   clk,
    input  logic                   rst_n,
    rit_char_if.sink               chars,
    rit_result_if.source           results,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int MW = MAX_VALUE_WIDTH;
    localparam int PW = MAX_VALUE_WIDTH + RADIX_W;
    localparam logic [6:0] MAX_W7 = 7'(MAX_VALUE_WIDTH);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGN,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_FAILED
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_FORMAT,
        ERR_TRAILING,
        ERR_BASE
    } err_t;

    typedef struct packed {
        phase_t          phase;
        err_t            sticky;
        logic            ovf;
        logic            neg;
        logic [MW-1:0]   mag;
    } snap_t;

    // Configuration registers
    logic [RADIX_W-1:0] radix_mode_reg;
    logic [1:0]         width_select_reg;
    logic               signed_mode_reg;

    // Parse state
    phase_t             phase_reg, phase_next;
    err_t               sticky_reg, sticky_next;
    logic               ovf_reg, ovf_next;
    logic               neg_reg, neg_next;
    logic [MW-1:0]      mag_reg, mag_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic               space_reg, space_next;

    // Pipeline registers
    logic               s1_valid_reg;
    logic [CHAR_W-1:0]  s1_char_reg;
    logic               s1_present_reg;
    logic               s1_eot_reg;
    logic               s2_valid_reg;
    snap_t              snap_reg, snap_next;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic out_free, s2_free, s2_move, s1_move, in_accept;

    assign out_free  = !out_valid_reg || results.ready;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s2_move   = s2_valid_reg && out_free;
    assign s1_move   = s1_valid_reg && (!s1_eot_reg || s2_free);
    assign chars.ready = !s1_valid_reg || s1_move;
    assign in_accept = chars.valid && chars.ready;

    // Character classification and the shared multiply-accumulate
    logic               blank, use_gap, feed;
    logic [CHAR_W-1:0]  lower;
    logic [RADIX_W:0]   dig;
    logic               d_ok, d_lt;
    logic [RADIX_W-1:0] d_val, base_r, run_r;
    logic               base_bad, prefix_radix;
    logic [PW-1:0]      prod;
    logic               do_run;
    err_t               run_err;

    always_comb
    begin
        blank   = is_blank(s1_char_reg);
        lower   = fold_case(s1_char_reg);
        feed    = s1_present_reg && !blank;
        // A blank run followed by more text acts as one invalid character.
        use_gap = space_reg;
        dig     = digit_of(s1_char_reg);
        d_ok    = dig[RADIX_W] && !use_gap;
        d_val   = dig[RADIX_W-1:0];
        base_r  = (phase_reg == PH_LEAD) ? radix_mode_reg : radix_reg;
        run_r   = (base_r == RADIX_AUTO) ? RADIX_DEC : base_r;
        d_lt    = d_ok && (d_val < run_r);
        base_bad = (base_r != RADIX_AUTO) && ((base_r < RADIX_MIN) || (base_r > RADIX_MAX));
        prefix_radix = (base_r == RADIX_AUTO) || (base_r == RADIX_HEX) ||
                       (base_r == RADIX_BIN) || (base_r == RADIX_OCT);
        prod    = PW'(mag_reg) * PW'(run_r) + PW'(d_val);
    end

    always_comb
    begin
        phase_next  = phase_reg;
        sticky_next = sticky_reg;
        ovf_next    = ovf_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        radix_next  = radix_reg;
        space_next  = space_reg;
        do_run      = 1'b0;
        run_err     = ERR_TRAILING;

        if (s1_present_reg && blank && (phase_reg != PH_LEAD))
        begin
            space_next = 1'b1;
        end

        if (feed)
        begin
            space_next = 1'b0;
            case (phase_reg)
                PH_LEAD, PH_SIGN:
                begin
                    if (phase_reg == PH_LEAD)
                    begin
                        radix_next = radix_mode_reg;
                    end
                    if ((phase_reg == PH_LEAD) &&
                        ((s1_char_reg == CH_PLUS) || (s1_char_reg == CH_MINUS)))
                    begin
                        neg_next   = (s1_char_reg == CH_MINUS);
                        phase_next = PH_SIGN;
                    end
                    else if (base_bad)
                    begin
                        phase_next  = PH_FAILED;
                        sticky_next = ERR_BASE;
                    end
                    else if (!use_gap && (s1_char_reg == CH_ZERO) && prefix_radix)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        radix_next = run_r;
                        phase_next = PH_DIGITS;
                        do_run     = 1'b1;
                        run_err    = ERR_FORMAT;
                    end
                end
                PH_ZERO:
                begin
                    if (!use_gap && (lower == CH_LOWER_X) &&
                        ((base_r == RADIX_AUTO) || (base_r == RADIX_HEX)))
                    begin
                        radix_next = RADIX_HEX;
                        phase_next = PH_PREFIX;
                    end
                    else if (!use_gap && (lower == CH_LOWER_B) &&
                             ((base_r == RADIX_AUTO) || (base_r == RADIX_BIN)))
                    begin
                        radix_next = RADIX_BIN;
                        phase_next = PH_PREFIX;
                    end
                    else if (!use_gap && (lower == CH_LOWER_O) &&
                             ((base_r == RADIX_AUTO) || (base_r == RADIX_OCT)))
                    begin
                        radix_next = RADIX_OCT;
                        phase_next = PH_PREFIX;
                    end
                    else
                    begin
                        radix_next = run_r;
                        phase_next = PH_DIGITS;
                        do_run     = 1'b1;
                        run_err    = ERR_TRAILING;
                    end
                end
                PH_PREFIX:
                begin
                    phase_next = PH_DIGITS;
                    do_run     = 1'b1;
                    run_err    = ERR_FORMAT;
                end
                PH_DIGITS:
                begin
                    do_run  = 1'b1;
                    run_err = ERR_TRAILING;
                end
                default:
                begin
                end
            endcase

            if (do_run)
            begin
                if (!d_lt)
                begin
                    phase_next  = PH_FAILED;
                    sticky_next = run_err;
                end
                else if (!ovf_reg)
                begin
                    // The magnitude only grows, so passing the widest target
                    // stays an overflow to the end of the text.
                    if (prod[PW-1:MW] != '0)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        mag_next = prod[MW-1:0];
                    end
                end
            end
        end

        snap_next.phase  = phase_next;
        snap_next.sticky = sticky_next;
        snap_next.ovf    = ovf_next;
        snap_next.neg    = neg_next;
        snap_next.mag    = mag_next;
    end

    // Result formation from the snapshot of a finished text
    logic [6:0]    w_sel, w_cur;
    logic [MW-1:0] high_m, top_m, low_m;
    logic          above_max, top_set, low_set;
    phase_t        phase_f;

    always_comb
    begin
        w_sel = 7'd8 << width_select_reg;
        w_cur = (w_sel > MAX_W7) ? MAX_W7 : w_sel;
        for (int i = 0; i < MW; i++)
        begin
            high_m[i] = (7'(i) >= w_cur);
            top_m[i]  = (7'(i) == (w_cur - 7'd1));
            low_m[i]  = (7'(i) < (w_cur - 7'd1));
        end
        above_max = |(snap_reg.mag & high_m);
        top_set   = |(snap_reg.mag & top_m);
        low_set   = |(snap_reg.mag & low_m);
        phase_f   = (snap_reg.phase == PH_ZERO) ? PH_DIGITS : snap_reg.phase;

        out_value_next  = '0;
        out_status_next = ST_OK;
        if (phase_f == PH_LEAD)
        begin
            out_status_next = ST_EMPTY;
        end
        else if (phase_f == PH_SIGN)
        begin
            out_status_next = ST_FORMAT;
        end
        else if (snap_reg.sticky == ERR_BASE)
        begin
            out_status_next = ST_BASE;
        end
        else if (phase_f == PH_PREFIX)
        begin
            out_status_next = ST_FORMAT;
        end
        else if (!signed_mode_reg && snap_reg.neg)
        begin
            out_status_next = ST_RANGE;
        end
        else if (snap_reg.sticky == ERR_FORMAT)
        begin
            out_status_next = ST_FORMAT;
        end
        else if (snap_reg.ovf || above_max)
        begin
            out_status_next = ST_RANGE;
        end
        else if (snap_reg.sticky == ERR_TRAILING)
        begin
            out_status_next = ST_TRAILING;
        end
        else if (!signed_mode_reg)
        begin
            out_value_next = VALUE_W'(snap_reg.mag);
        end
        else if (snap_reg.neg)
        begin
            if (top_set && low_set)
            begin
                out_status_next = ST_RANGE;
            end
            else
            begin
                out_value_next = '0 - VALUE_W'(snap_reg.mag);
            end
        end
        else
        begin
            if (top_set)
            begin
                out_status_next = ST_RANGE;
            end
            else
            begin
                out_value_next = VALUE_W'(snap_reg.mag);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_mode_reg   <= RADIX_RESET;
            width_select_reg <= 2'd2;
            signed_mode_reg  <= 1'b1;
            phase_reg        <= PH_LEAD;
            sticky_reg       <= ERR_NONE;
            ovf_reg          <= 1'b0;
            neg_reg          <= 1'b0;
            mag_reg          <= '0;
            radix_reg        <= RADIX_AUTO;
            space_reg        <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_value_reg    <= '0;
            out_status_reg   <= ST_OK;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_RADIX_MODE:   radix_mode_reg   <= cfg_data[RADIX_W-1:0];
                    REG_WIDTH_SELECT: width_select_reg <= cfg_data[1:0];
                    REG_SIGNED_MODE:  signed_mode_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            if (s1_move)
            begin
                if (s1_eot_reg)
                begin
                    phase_reg  <= PH_LEAD;
                    sticky_reg <= ERR_NONE;
                    ovf_reg    <= 1'b0;
                    neg_reg    <= 1'b0;
                    mag_reg    <= '0;
                    radix_reg  <= RADIX_AUTO;
                    space_reg  <= 1'b0;
                end
                else
                begin
                    phase_reg  <= phase_next;
                    sticky_reg <= sticky_next;
                    ovf_reg    <= ovf_next;
                    neg_reg    <= neg_next;
                    mag_reg    <= mag_next;
                    radix_reg  <= radix_next;
                    space_reg  <= space_next;
                end
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move && s1_eot_reg)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_move)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_move)
            begin
                out_valid_reg  <= 1'b1;
                out_value_reg  <= out_value_next;
                out_status_reg <= out_status_next;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_char_reg    <= chars.char_code;
            s1_present_reg <= chars.char_present;
            s1_eot_reg     <= chars.end_of_text;
        end
        if (s1_move && s1_eot_reg)
        begin
            snap_reg <= snap_next;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.value_bits = out_value_reg;
    assign results.status     = out_status_reg;

endmodule

/* src/rit_checker.sv */
// Port-level checks for the radix integer text parser and their binding.
`timescale 1ns / 1ps

module rit_checker
    import rit_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [VALUE_W-1:0]  value_bits,
    input logic [STATUS_W-1:0] status
);

    // Any failing status carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (value_bits == '0))
        else $error("nonzero value on an error result");

    // The input side only backs up behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while the result side is free");

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(value_bits) && $stable(status)))
        else $error("stalled result word changed");

endmodule

bind radix_integer_text_parser rit_checker u_rit_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (chars.valid),
    .in_ready   (chars.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .value_bits (results.value_bits),
    .status     (results.status)
);

/* sim/tb_top.sv */
// Self-checking testbench for the radix integer text parser: directed texts, then random ones.
`timescale 1ns / 1ps

module tb_top;
    import rit_pkg::*;

    typedef enum logic [2:0] {
        P_LEAD,
        P_SIGN,
        P_ZERO,
        P_PREFIX,
        P_DIGITS,
        P_FAILED
    } parse_phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } outcome_t;

    typedef struct packed {
        logic                fixed;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } answer_t;

    typedef struct {
        string               text;
        logic                bare;
        logic [RADIX_W-1:0]  radix;
        logic [1:0]          wsel;
        logic                sgn;
        logic                fixed;
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } table_row_t;

    localparam int DIR_ROWS = 25;
    localparam int PHASES = 10;
    localparam int WORDS_PER_PHASE = 140;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [8:0] GAP_MARK = 9'h100;
    localparam logic [CHAR_W-1:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C, 8'h0B};

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    rit_char_if   chars_if ();
    rit_result_if results_if ();

    radix_integer_text_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .results   (results_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the configuration registers.
    logic [RADIX_W-1:0] sh_radix = RADIX_RESET;
    logic [1:0]         sh_width = 2'd2;
    logic               sh_signed = 1'b1;

    // Parse state of the predictor.
    parse_phase_t       ps_phase = P_LEAD;
    logic [63:0]        ps_mag = '0;
    logic               ps_over = 1'b0;
    logic               ps_neg = 1'b0;
    logic [RADIX_W-1:0] ps_radix = '0;
    logic [2:0]         ps_err = ST_OK;
    logic               ps_gap = 1'b0;

    outcome_t    awaited_results [$];
    answer_t     table_answers [$];
    logic [7:0]  text_buf [$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;

    table_row_t dir_rows [DIR_ROWS] = '{
        '{"", 1'b1, RADIX_DEC, 2'd2, 1'b1, 1'b1, 64'd0, ST_EMPTY},
        '{"  \t42 \n", 1'b0, RADIX_DEC, 2'd2, 1'b1, 1'b1, 64'd42, ST_OK},
        '{"-", 1'b1, RADIX_DEC, 2'd2, 1'b1, 1'b1, 64'd0, ST_FORMAT},
        '{"+2147483647", 1'b0, RADIX_DEC, 2'd2, 1'b1, 1'b1, 64'd2147483647, ST_OK},
        '{"-2147483648", 1'b1, RADIX_DEC, 2'd2, 1'b1, 1'b1, 64'hFFFF_FFFF_8000_0000, ST_OK},
        '{"2147483648", 1'b0, RADIX_DEC, 2'd2, 1'b1, 1'b1, 64'd0, ST_RANGE},
        '{"12a", 1'b1, RADIX_DEC, 2'd2, 1'b1, 1'b1, 64'd0, ST_TRAILING},
        '{"1 2", 1'b0, RADIX_DEC, 2'd2, 1'b1, 1'b1, 64'd0, ST_TRAILING},
        '{"x5", 1'b1, RADIX_DEC, 2'd2, 1'b1, 1'b1, 64'd0, ST_FORMAT},
        '{"1\3772", 1'b0, RADIX_DEC, 2'd2, 1'b1, 1'b1, 64'd0, ST_TRAILING},
        '{"0x1F", 1'b1, RADIX_AUTO, 2'd3, 1'b1, 1'b0, 64'd0, ST_OK},
        '{"-0O17", 1'b0, RADIX_AUTO, 2'd3, 1'b1, 1'b0, 64'd0, ST_OK},
        '{"0", 1'b1, RADIX_AUTO, 2'd3, 1'b1, 1'b1, 64'd0, ST_OK},
        '{"0x", 1'b0, RADIX_AUTO, 2'd3, 1'b1, 1'b1, 64'd0, ST_FORMAT},
        '{"0129", 1'b1, RADIX_AUTO, 2'd3, 1'b1, 1'b0, 64'd0, ST_OK},
        '{"zZ", 1'b0, RADIX_MAX, 2'd3, 1'b0, 1'b0, 64'd0, ST_OK},
        '{"18446744073709551615", 1'b1, RADIX_DEC, 2'd3, 1'b0, 1'b1, ALL_ONES, ST_OK},
        '{"18446744073709551616", 1'b0, RADIX_DEC, 2'd3, 1'b0, 1'b1, 64'd0, ST_RANGE},
        '{"-0", 1'b1, RADIX_DEC, 2'd3, 1'b0, 1'b1, 64'd0, ST_RANGE},
        '{"-9223372036854775808", 1'b0, RADIX_DEC, 2'd3, 1'b1, 1'b1,
          64'h8000_0000_0000_0000, ST_OK},
        '{"-128", 1'b1, RADIX_DEC, 2'd0, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FF80, ST_OK},
        '{"128", 1'b0, RADIX_DEC, 2'd0, 1'b1, 1'b1, 64'd0, ST_RANGE},
        '{"0XfFfF", 1'b1, RADIX_HEX, 2'd1, 1'b0, 1'b1, 64'd65535, ST_OK},
        '{"7", 1'b0, 6'd1, 2'd2, 1'b1, 1'b1, 64'd0, ST_BASE},
        '{"+1", 1'b1, 6'd63, 2'd2, 1'b1, 1'b1, 64'd0, ST_BASE}
    };

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [8:0] fold9(input logic [8:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D ||
               c == 8'h0C || c == 8'h0B;
    endfunction

    // Digit weight of a character; 255 for anything that is not a digit or a letter.
    function automatic logic [63:0] digit_value(input logic [8:0] c);
        logic [8:0] l;
        l = fold9(c);
        if (l >= CH_ZERO && l <= CH_NINE)
            return 64'(l - CH_ZERO);
        if (l >= CH_LOWER_A && l <= CH_LOWER_Z)
            return 64'(l - CH_LOWER_A) + 64'd10;
        return 64'd255;
    endfunction

    function automatic void clear_parse();
        ps_phase = P_LEAD;
        ps_mag = '0;
        ps_over = 1'b0;
        ps_neg = 1'b0;
        ps_radix = '0;
        ps_err = ST_OK;
        ps_gap = 1'b0;
    endfunction

    function automatic void flag_error(input logic [2:0] code);
        ps_phase = P_FAILED;
        ps_err = code;
    endfunction

    function automatic void accumulate(input logic [8:0] c);
        logic [63:0] d;
        logic [63:0] r;
        d = digit_value(c);
        r = {58'd0, ps_radix};
        if (d >= r)
        begin
            flag_error(ST_TRAILING);
            return;
        end
        if (ps_over)
            return;
        if (ps_mag > (ALL_ONES - d) / r)
            ps_over = 1'b1;
        else
            ps_mag = ps_mag * r + d;
    endfunction

    function automatic void first_digit(input logic [8:0] c);
        if (digit_value(c) >= {58'd0, ps_radix})
        begin
            flag_error(ST_FORMAT);
            return;
        end
        ps_phase = P_DIGITS;
        accumulate(c);
    endfunction

    function automatic void open_number(input logic [8:0] c);
        if (ps_radix != RADIX_AUTO && (ps_radix < RADIX_MIN || ps_radix > RADIX_MAX))
        begin
            flag_error(ST_BASE);
            return;
        end
        if (c == {1'b0, CH_ZERO} && (ps_radix == RADIX_AUTO || ps_radix == RADIX_HEX ||
                                    ps_radix == RADIX_BIN || ps_radix == RADIX_OCT))
        begin
            ps_phase = P_ZERO;
            return;
        end
        if (ps_radix == RADIX_AUTO)
            ps_radix = RADIX_DEC;
        first_digit(c);
    endfunction

    function automatic void take_char(input logic [8:0] c);
        logic [8:0]         l;
        logic [RADIX_W-1:0] r;
        l = fold9(c);
        r = ps_radix;
        case (ps_phase)
            P_LEAD:
            begin
                ps_radix = sh_radix;
                if (c == {1'b0, CH_PLUS} || c == {1'b0, CH_MINUS})
                begin
                    ps_neg = (c == {1'b0, CH_MINUS});
                    ps_phase = P_SIGN;
                end
                else
                    open_number(c);
            end
            P_SIGN:
                open_number(c);
            P_ZERO:
            begin
                if ((r == RADIX_AUTO || r == RADIX_HEX) && l == {1'b0, CH_LOWER_X})
                begin
                    ps_radix = RADIX_HEX;
                    ps_phase = P_PREFIX;
                end
                else if ((r == RADIX_AUTO || r == RADIX_BIN) && l == {1'b0, CH_LOWER_B})
                begin
                    ps_radix = RADIX_BIN;
                    ps_phase = P_PREFIX;
                end
                else if ((r == RADIX_AUTO || r == RADIX_OCT) && l == {1'b0, CH_LOWER_O})
                begin
                    ps_radix = RADIX_OCT;
                    ps_phase = P_PREFIX;
                end
                else
                begin
                    if (r == RADIX_AUTO)
                        ps_radix = RADIX_DEC;
                    ps_phase = P_DIGITS;
                    ps_mag = '0;
                    accumulate(c);
                end
            end
            P_PREFIX:
                first_digit(c);
            P_DIGITS:
                accumulate(c);
            default:
                ;
        endcase
    endfunction

    // Whitespace inside the text only counts once another character follows it.
    function automatic void read_word(input logic [7:0] c);
        if (is_space(c))
        begin
            if (ps_phase != P_LEAD)
                ps_gap = 1'b1;
        end
        else
        begin
            if (ps_gap)
            begin
                ps_gap = 1'b0;
                take_char(GAP_MARK);
            end
            take_char({1'b0, c});
        end
    endfunction

    function automatic outcome_t close_text();
        outcome_t    o;
        int unsigned w;
        logic [63:0] umax;
        logic [63:0] half;
        o.value = '0;
        o.status = ST_OK;
        w = 8 << sh_width;
        if (w > 64)
            w = 64;
        umax = (w >= 64) ? ALL_ONES : ((64'd1 << w) - 64'd1);
        half = 64'd1 << (w - 1);
        if (ps_phase == P_ZERO)
            ps_phase = P_DIGITS;
        if (ps_phase == P_LEAD)
            o.status = ST_EMPTY;
        else if (ps_phase == P_SIGN)
            o.status = ST_FORMAT;
        else if (ps_err == ST_BASE)
            o.status = ST_BASE;
        else if (ps_phase == P_PREFIX)
            o.status = ST_FORMAT;
        else if (!sh_signed && ps_neg)
            o.status = ST_RANGE;
        else if (ps_err == ST_FORMAT)
            o.status = ST_FORMAT;
        else if (ps_over || ps_mag > umax)
            o.status = ST_RANGE;
        else if (ps_err == ST_TRAILING)
            o.status = ST_TRAILING;
        else if (!sh_signed)
            o.value = ps_mag;
        else if (ps_neg)
        begin
            if (ps_mag > half)
                o.status = ST_RANGE;
            else
                o.value = 64'd0 - ps_mag;
        end
        else
        begin
            if (ps_mag > half - 64'd1)
                o.status = ST_RANGE;
            else
                o.value = ps_mag;
        end
        clear_parse();
        return o;
    endfunction

    // Every accepted word that carries a character advances the predictor; an end word queues its result.
    always @(posedge clk)
    begin
        answer_t ans;
        outcome_t o;
        if (rst_n && chars_if.valid && chars_if.ready)
        begin
            if (chars_if.char_present)
                read_word(chars_if.char_code);
            if (chars_if.end_of_text)
            begin
                o = close_text();
                ans = '0;
                if (table_answers.size() != 0)
                    ans = table_answers.pop_front();
                if (ans.fixed)
                    awaited_results.push_back({ans.value, ans.status});
                else
                    awaited_results.push_back(o);
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t ns: result with nothing expected: value %h status %0d",
                         $time, results_if.value_bits, results_if.status);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (results_if.value_bits !== want.value || results_if.status !== want.status)
                begin
                    $display("%0t ns: mismatch: expected value %h status %0d, got value %h status %0d",
                             $time, want.value, want.status, results_if.value_bits,
                             results_if.status);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        results_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            results_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_word(input logic [7:0] code, input logic present, input logic last);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.char_code <= code;
        chars_if.char_present <= present;
        chars_if.end_of_text <= last;
        do
            @(posedge clk);
        while (!chars_if.ready);
        if (present || last)
            words_sent++;
    endtask

    task automatic send_text(input logic bare_end, input int noise_pct, input answer_t answer);
        int n;
        n = text_buf.size();
        table_answers.push_back(answer);
        for (int i = 0; i < n; i++)
        begin
            while ($urandom_range(99) < noise_pct)
                send_word(8'($urandom_range(255)), 1'b0, 1'b0);
            send_word(text_buf[i], 1'b1, (i == n - 1) && !bare_end);
        end
        if (bare_end || n == 0)
            send_word(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // Sender goes quiet until every result is in, then waits out the pipeline.
    task automatic wait_for_results();
        int guard;
        guard = 0;
        chars_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (awaited_results.size() != 0 && guard < 50000);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [RADIX_W-1:0] radix, input logic [1:0] wsel,
                              input logic sgn);
        cfg_write <= 1'b1;
        cfg_index <= REG_RADIX_MODE;
        cfg_data <= radix;
        @(posedge clk);
        cfg_index <= REG_WIDTH_SELECT;
        cfg_data <= {4'($urandom_range(15)), wsel};
        @(posedge clk);
        cfg_index <= REG_SIGNED_MODE;
        cfg_data <= {5'($urandom_range(31)), sgn};
        @(posedge clk);
        cfg_write <= 1'b0;
        sh_radix = radix;
        sh_width = wsel;
        sh_signed = sgn;
    endtask

    function automatic logic [7:0] digit_char(input logic [63:0] v);
        if (v < 10)
            return CH_ZERO + v[7:0];
        return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + v[7:0] - 8'd10;
    endfunction

    // Mostly well-formed numbers near the range limits of the current width,
    // with some empty texts, junk bytes and corrupted numbers mixed in.
    task automatic build_random_text(output logic bare, output int noise);
        int          kind;
        int          n;
        int          pos;
        logic        pfx;
        logic        longer;
        logic [63:0] rend;
        logic [63:0] m;
        logic [63:0] umax;
        logic [63:0] half;
        logic [7:0]  dig [64];
        logic [7:0]  letter;
        text_buf.delete();
        bare = 1'($urandom_range(1));
        noise = ($urandom_range(9) == 0) ? 30 : 0;
        kind = $urandom_range(99);
        if (kind < 4)
        begin
            repeat ($urandom_range(2)) text_buf.push_back(BLANKS[$urandom_range(5)]);
            return;
        end
        if (kind < 9)
        begin
            repeat ($urandom_range(6, 1)) text_buf.push_back(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(9) < 3)
            repeat ($urandom_range(2, 1)) text_buf.push_back(BLANKS[$urandom_range(5)]);
        kind = $urandom_range(9);
        if (kind < 2)
            text_buf.push_back(CH_MINUS);
        else if (kind < 3)
            text_buf.push_back(CH_PLUS);
        pfx = 1'b0;
        if (sh_radix == RADIX_AUTO)
        begin
            case ($urandom_range(3))
                0: rend = 64'(RADIX_DEC);
                1: rend = 64'(RADIX_HEX);
                2: rend = 64'(RADIX_BIN);
                default: rend = 64'(RADIX_OCT);
            endcase
            pfx = (rend != RADIX_DEC);
        end
        else if (sh_radix == RADIX_HEX || sh_radix == RADIX_BIN || sh_radix == RADIX_OCT)
        begin
            rend = 64'(sh_radix);
            pfx = ($urandom_range(4) < 2);
        end
        else if (sh_radix < RADIX_MIN || sh_radix > RADIX_MAX)
            rend = 64'(RADIX_DEC);
        else
            rend = 64'(sh_radix);
        if (pfx)
        begin
            letter = (rend == RADIX_HEX) ? CH_LOWER_X :
                     (rend == RADIX_BIN) ? CH_LOWER_B : CH_LOWER_O;
            if ($urandom_range(1))
                letter = letter - CASE_OFFSET;
            text_buf.push_back(CH_ZERO);
            text_buf.push_back(letter);
        end
        else if ($urandom_range(9) == 0)
            repeat ($urandom_range(3, 1)) text_buf.push_back(CH_ZERO);
        if (!(pfx && $urandom_range(19) == 0))
        begin
            umax = (sh_width == 2'd3) ? ALL_ONES : ((64'd1 << (8 << sh_width)) - 64'd1);
            half = 64'd1 << ((8 << sh_width) - 1);
            longer = 1'b0;
            case ($urandom_range(9))
                0: m = '0;
                1: m = umax;
                2: m = umax + 64'd1;
                3: m = half;
                4: m = half - 64'd1;
                5: m = half + 64'd1;
                6, 7: m = {$urandom, $urandom} >> $urandom_range(63);
                8: m = 64'($urandom_range(99));
                default:
                begin
                    m = {$urandom, $urandom};
                    longer = 1'b1;
                end
            endcase
            n = 0;
            do
            begin
                dig[n] = digit_char(m % rend);
                m = m / rend;
                n++;
            end
            while (m != 0);
            for (int i = n - 1; i >= 0; i--)
                text_buf.push_back(dig[i]);
            if (longer)
                repeat ($urandom_range(3, 1))
                    text_buf.push_back(digit_char(64'($urandom_range(int'(rend) - 1))));
        end
        if ($urandom_range(9) < 3)
            repeat ($urandom_range(2, 1)) text_buf.push_back(BLANKS[$urandom_range(5)]);
        if ($urandom_range(99) < 15)
        begin
            pos = $urandom_range(text_buf.size());
            case ($urandom_range(2))
                0: text_buf.insert(pos, 8'($urandom_range(255)));
                1: text_buf.insert(pos, BLANKS[$urandom_range(5)]);
                default:
                    if (text_buf.size() != 0)
                        text_buf[pos % text_buf.size()] = 8'($urandom_range(255));
            endcase
        end
    endtask

    // ---------------------------------------------------------------- main

    initial
    begin
        logic [RADIX_W-1:0] radix_plan [PHASES];
        logic [1:0]         width_plan [PHASES];
        logic               bare;
        int                 noise;
        int                 start;
        string              s;
        radix_plan = '{RADIX_DEC, RADIX_AUTO, RADIX_MIN, RADIX_MAX, RADIX_HEX, RADIX_OCT,
                       RADIX_AUTO, 6'd1, 6'd7, RADIX_AUTO};
        width_plan = '{2'd3, 2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3, 2'd3};
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_RADIX_MODE;
        cfg_data <= '0;
        chars_if.valid <= 1'b0;
        chars_if.char_code <= '0;
        chars_if.char_present <= 1'b0;
        chars_if.end_of_text <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].radix != sh_radix || dir_rows[i].wsel != sh_width ||
                dir_rows[i].sgn != sh_signed)
            begin
                wait_for_results();
                set_config(dir_rows[i].radix, dir_rows[i].wsel, dir_rows[i].sgn);
            end
            s = dir_rows[i].text;
            text_buf.delete();
            for (int j = 0; j < s.len(); j++)
                text_buf.push_back(s[j]);
            send_text(dir_rows[i].bare, 0,
                      {dir_rows[i].fixed, dir_rows[i].value, dir_rows[i].status});
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_for_results();
            if (radix_plan[p] == 6'd1 && $urandom_range(1))
                set_config(6'($urandom_range(63, 37)), width_plan[p], 1'(p % 2));
            else
                set_config(radix_plan[p], width_plan[p], 1'(p % 2));
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
                default: begin src_idle_pct = 33; sink_stall_pct = 33; end
            endcase
            start = words_sent;
            while (words_sent - start < WORDS_PER_PHASE)
            begin
                build_random_text(bare, noise);
                send_text(bare, noise, '0);
            end
        end

        wait_for_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("radix_integer_text_parser regression: pass");
        else
            $display("radix_integer_text_parser regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("radix_integer_text_parser regression: fail");
        $finish;
    end

endmodule
